// ===== src/cbeb_pkg.sv =====
`timescale 1ns / 1ps
package cbeb_pkg;
	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_COMPUTE = 1'b1;
	localparam int   NUM_AXES    = 2;
endpackage

// ===== src/cbeb_axis.sv =====
`timescale 1ns / 1ps
// One axis lane: derivative coefficients, discriminant, digit-by-digit square
// root, up to two restoring divisions and Horner evaluation.
module cbeb_axis #(
	parameter int CW = 32,
	parameter int TF = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [CW-1:0] v0,
	input  logic signed [CW-1:0] v1,
	input  logic signed [CW-1:0] v2,
	input  logic signed [CW-1:0] v3,
	input  logic signed [CW-1:0] c3,
	input  logic signed [CW-1:0] c2,
	input  logic signed [CW-1:0] c1,
	input  logic signed [CW-1:0] c0,
	output logic                 done,
	output logic signed [CW-1:0] lo,
	output logic signed [CW-1:0] hi,
	output logic [1:0]           cnt,
	output logic [TF:0]          t0,
	output logic [TF:0]          t1
);
	import cbeb_pkg::*;

	localparam int AW = CW + 4;
	localparam int DW = 2 * AW + 2;
	localparam int SW = AW + 2;
	localparam int SCW = $clog2(SW + 1);
	localparam int TCW = $clog2(TF + 1);
	localparam int PW = 2 * AW;
	localparam int EW = CW + TF + 2;
	localparam logic [TF:0] T_ONE = (TF+1)'(1) << TF;
	localparam logic signed [CW-1:0] SMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] SMIN = {1'b1, {(CW-1){1'b0}}};

	typedef enum logic [3:0] {
		ST_IDLE, ST_COEF, ST_DISC, ST_SQRT, ST_DIV_SETUP, ST_DIV, ST_DIV_END,
		ST_EVAL, ST_DONE
	} state_t;

	state_t state_q;
	logic signed [AW-1:0] a_q, b_q, c_q;
	logic signed [DW-1:0] d_q;
	logic [SW-1:0] s_q;
	logic [SW+1:0] rem_q;
	logic [SCW-1:0] bit_q;
	logic cand_q;
	logic [SW+1:0] n_q, den_q;
	logic [TF-1:0] q_q;
	logic [TCW-1:0] ti_q;
	logic [1:0] cnt_q;
	logic [TF-1:0] tr_q [2];
	logic [1:0] ev_q;
	logic [1:0] hs_q;
	logic signed [CW-1:0] acc_q, lo_q, hi_q;

	// Combinational helpers
	logic signed [AW-1:0] sv0, sv1, sv2, sv3;
	logic signed [DW-1:0] b2, ac;
	logic [2*SW-1:0] d_ext;
	logic [1:0] d_pair;
	logic [SW+1:0] rem_sh, trial;
	logic signed [AW+2:0] num_c, den_c, num_n, den_n;
	logic [SW+1:0] n_sh;
	logic [TF-1:0] cur_t;
	logic [CW-1:0] acc_mag;
	logic [CW+TF-1:0] prod;
	logic signed [EW-1:0] scaled, addend, sum;
	logic signed [CW-1:0] sat_sum;

	assign sv0 = AW'(v0);
	assign sv1 = AW'(v1);
	assign sv2 = AW'(v2);
	assign sv3 = AW'(v3);
	assign b2 = DW'(b_q) * DW'(b_q);
	assign ac = DW'(a_q) * DW'(c_q);

	// Bring down the next two radicand bits and form the trial subtrahend
	assign d_ext = {2'b00, d_q};
	assign d_pair = d_ext[{bit_q, 1'b0} +: 2];
	assign rem_sh = {rem_q[SW-1:0], d_pair};
	assign trial = {s_q, 2'b01};

	// Candidate numerator and denominator for the current root
	always_comb begin
		if (a_q == '0) begin
			num_c = -(AW+3)'(c_q);
			den_c = (AW+3)'(b_q) <<< 1;
		end else if (!cand_q) begin
			num_c = -(AW+3)'(b_q) + (AW+3)'(s_q);
			den_c = (AW+3)'(a_q);
		end else begin
			num_c = -(AW+3)'(b_q) - (AW+3)'(s_q);
			den_c = (AW+3)'(a_q);
		end
		if (den_c < 0) begin
			num_n = -num_c;
			den_n = -den_c;
		end else begin
			num_n = num_c;
			den_n = den_c;
		end
	end

	assign n_sh = n_q << 1;
	assign cur_t = tr_q[hs_q[0]];
	assign acc_mag = acc_q[CW-1] ? CW'(-acc_q) : CW'(acc_q);
	assign prod = (CW+TF)'(acc_mag) * (CW+TF)'(cur_t);
	assign scaled = acc_q[CW-1] ? -EW'(prod >> TF) : EW'(prod >> TF);
	always_comb begin
		case (ev_q)
			2'd0:    addend = EW'(c2);
			2'd1:    addend = EW'(c1);
			default: addend = EW'(c0);
		endcase
	end
	assign sum = scaled + addend;
	assign sat_sum = (sum > EW'(SMAX)) ? SMAX : (sum < EW'(SMIN)) ? SMIN : CW'(sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						a_q <= -sv0 + 3 * sv1 - 3 * sv2 + sv3;
						b_q <= sv0 - 2 * sv1 + sv2;
						c_q <= sv1 - sv0;
						lo_q <= (v0 < v3) ? v0 : v3;
						hi_q <= (v0 < v3) ? v3 : v0;
						cnt_q <= '0;
						cand_q <= 1'b0;
						state_q <= ST_COEF;
					end
				end
				ST_COEF: begin
					if (a_q == '0) begin
						state_q <= (b_q != '0) ? ST_DIV_SETUP : ST_EVAL;
						hs_q <= '0;
						ev_q <= '0;
					end else begin
						d_q <= b2 - ac;
						state_q <= ST_DISC;
					end
				end
				ST_DISC: begin
					s_q <= '0;
					rem_q <= '0;
					bit_q <= SCW'(SW - 1);
					if (d_q > 0) state_q <= ST_SQRT;
					else begin
						hs_q <= '0;
						state_q <= ST_EVAL;
					end
				end
				// Resolve one square-root bit per cycle
				ST_SQRT: begin
					if (rem_sh >= trial) begin
						rem_q <= rem_sh - trial;
						s_q <= {s_q[SW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						s_q <= {s_q[SW-2:0], 1'b0};
					end
					if (bit_q == '0) state_q <= ST_DIV_SETUP;
					else bit_q <= bit_q - 1'b1;
				end
				ST_DIV_SETUP: begin
					n_q <= (SW+2)'(num_n);
					den_q <= (SW+2)'(den_n);
					q_q <= '0;
					ti_q <= '0;
					if (num_n > 0 && num_n < den_n) state_q <= ST_DIV;
					else state_q <= ST_DIV_END;
				end
				// Restoring division, one quotient bit per cycle
				ST_DIV: begin
					if (n_sh >= den_q) begin
						n_q <= n_sh - den_q;
						q_q <= {q_q[TF-2:0], 1'b1};
					end else begin
						n_q <= n_sh;
						q_q <= {q_q[TF-2:0], 1'b0};
					end
					if (ti_q == TCW'(TF - 1)) begin
						tr_q[cnt_q[0]] <= (n_sh >= den_q) ? {q_q[TF-2:0], 1'b1}
						                                  : {q_q[TF-2:0], 1'b0};
						cnt_q <= cnt_q + 1'b1;
						state_q <= ST_DIV_END;
					end else ti_q <= ti_q + 1'b1;
				end
				ST_DIV_END: begin
					if (a_q != '0 && !cand_q) begin
						cand_q <= 1'b1;
						state_q <= ST_DIV_SETUP;
					end else begin
						hs_q <= '0;
						ev_q <= '0;
						acc_q <= c3;
						state_q <= ST_EVAL;
					end
				end
				// Horner steps per kept root
				ST_EVAL: begin
					if (hs_q >= {1'b0, cnt_q[1] | cnt_q[0]} + {1'b0, cnt_q[1]}) begin
						state_q <= ST_DONE;
					end else if (ev_q == 2'd2) begin
						if (sat_sum < lo_q) lo_q <= sat_sum;
						if (sat_sum > hi_q) hi_q <= sat_sum;
						ev_q <= '0;
						acc_q <= c3;
						hs_q <= hs_q + 1'b1;
					end else begin
						acc_q <= sat_sum;
						ev_q <= ev_q + 1'b1;
					end
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done = (state_q == ST_DONE);
	assign lo = lo_q;
	assign hi = hi_q;
	assign cnt = cnt_q;
	assign t0 = (cnt_q != 2'd0) ? {1'b0, tr_q[0]} : T_ONE;
	assign t1 = (cnt_q == 2'd2) ? {1'b0, tr_q[1]} : T_ONE;
endmodule

// ===== src/cbeb_merge.sv =====
`timescale 1ns / 1ps
// Merge the two lanes: sort four roots with a small network.
module cbeb_merge #(
	parameter int TF = 16
) (
	input  logic [TF:0] x0,
	input  logic [TF:0] x1,
	input  logic [TF:0] y0,
	input  logic [TF:0] y1,
	output logic [TF:0] r0,
	output logic [TF:0] r1,
	output logic [TF:0] r2,
	output logic [TF:0] r3
);
	import cbeb_pkg::*;

	logic [TF:0] a0, a1, b0, b1, m1, m2;

	// Order each pair, then merge
	assign a0 = (x0 < x1) ? x0 : x1;
	assign a1 = (x0 < x1) ? x1 : x0;
	assign b0 = (y0 < y1) ? y0 : y1;
	assign b1 = (y0 < y1) ? y1 : y0;
	assign r0 = (a0 < b0) ? a0 : b0;
	assign m1 = (a0 < b0) ? b0 : a0;
	assign r3 = (a1 < b1) ? b1 : a1;
	assign m2 = (a1 < b1) ? a1 : b1;
	assign r1 = (m1 < m2) ? m1 : m2;
	assign r2 = (m1 < m2) ? m2 : m1;
endmodule

// ===== src/cubic_bezier_extrema_bounds_core.sv =====
`timescale 1ns / 1ps
// Cubic Bezier bounding box with derivative extrema.
// Input channel (in_valid/in_stall): action 0 stores the four control points
// and yields no result; action 1 carries power-basis coefficients and starts
// a computation that yields exactly one result on the output channel
// (out_valid/out_stall).
// Two axis lanes run side by side; each resolves a square root of SW bits
// (SW = COORD_WIDTH + 6), one bit a cycle, then up to two divisions of
// T_FRAC_BITS quotient bits each and the Horner evaluation of each kept root.
// The next compute is taken only after the result of the last one has
// moved into the output register.
// A load transaction does not set the input stall. One compute is in flight at a
// time; input stalls from acceptance until the lanes finish and the result
// register is free.
// The result register holds its transaction while out_stall is high.
// Reset clears the stored control points to zero and empties the pipeline.
module cubic_bezier_extrema_bounds_core #(
	parameter int COORD_WIDTH = 32,
	parameter int T_FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic signed [COORD_WIDTH-1:0] p0_x,
	input  logic signed [COORD_WIDTH-1:0] p0_y,
	input  logic signed [COORD_WIDTH-1:0] p1_x,
	input  logic signed [COORD_WIDTH-1:0] p1_y,
	input  logic signed [COORD_WIDTH-1:0] p2_x,
	input  logic signed [COORD_WIDTH-1:0] p2_y,
	input  logic signed [COORD_WIDTH-1:0] p3_x,
	input  logic signed [COORD_WIDTH-1:0] p3_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0] min_x,
	output logic signed [COORD_WIDTH-1:0] min_y,
	output logic signed [COORD_WIDTH-1:0] max_x,
	output logic signed [COORD_WIDTH-1:0] max_y,
	output logic [T_FRAC_BITS:0]          root_0,
	output logic [T_FRAC_BITS:0]          root_1,
	output logic [T_FRAC_BITS:0]          root_2,
	output logic [T_FRAC_BITS:0]          root_3,
	output logic [1:0]                    count_x,
	output logic [1:0]                    count_y
);
	import cbeb_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int TF = T_FRAC_BITS;

	logic signed [CW-1:0] cp_q [8];
	logic signed [CW-1:0] cf_q [8];
	logic busy_q, start_q, pend_q;
	logic [1:0] got_q;
	logic accept;
	logic [NUM_AXES-1:0] done;
	logic signed [CW-1:0] lo [NUM_AXES];
	logic signed [CW-1:0] hi [NUM_AXES];
	logic [1:0] cnt [NUM_AXES];
	logic [TF:0] ta [NUM_AXES];
	logic [TF:0] tb [NUM_AXES];
	logic signed [CW-1:0] lo_q [NUM_AXES];
	logic signed [CW-1:0] hi_q [NUM_AXES];
	logic [1:0] cnt_q [NUM_AXES];
	logic [TF:0] ta_q [NUM_AXES];
	logic [TF:0] tb_q [NUM_AXES];
	logic [TF:0] r0, r1, r2, r3;

	assign in_stall = busy_q;
	assign accept = in_valid && !in_stall;

	genvar g;
	generate
		for (g = 0; g < NUM_AXES; g++) begin : g_lane
			cbeb_axis #(.CW(CW), .TF(TF)) u_axis (
				.clk(clk), .arst_n(arst_n), .start(start_q),
				.v0(cp_q[g]), .v1(cp_q[2+g]), .v2(cp_q[4+g]), .v3(cp_q[6+g]),
				.c3(cf_q[g]), .c2(cf_q[2+g]), .c1(cf_q[4+g]), .c0(cf_q[6+g]),
				.done(done[g]), .lo(lo[g]), .hi(hi[g]), .cnt(cnt[g]),
				.t0(ta[g]), .t1(tb[g])
			);
		end
	endgenerate

	cbeb_merge #(.TF(TF)) u_merge (
		.x0(ta_q[0]), .x1(tb_q[0]), .y0(ta_q[1]), .y1(tb_q[1]),
		.r0(r0), .r1(r1), .r2(r2), .r3(r3)
	);

	// Store control points, latch coefficients, collect lane results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) cp_q[i] <= '0;
			busy_q <= 1'b0;
			start_q <= 1'b0;
			pend_q <= 1'b0;
			got_q <= '0;
			out_valid <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (accept) begin
				if (action == ACT_LOAD) begin
					cp_q[0] <= p0_x; cp_q[1] <= p0_y; cp_q[2] <= p1_x; cp_q[3] <= p1_y;
					cp_q[4] <= p2_x; cp_q[5] <= p2_y; cp_q[6] <= p3_x; cp_q[7] <= p3_y;
				end else begin
					cf_q[0] <= p0_x; cf_q[1] <= p0_y; cf_q[2] <= p1_x; cf_q[3] <= p1_y;
					cf_q[4] <= p2_x; cf_q[5] <= p2_y; cf_q[6] <= p3_x; cf_q[7] <= p3_y;
					busy_q <= 1'b1;
					start_q <= 1'b1;
					got_q <= '0;
				end
			end
			for (int i = 0; i < NUM_AXES; i++) begin
				if (done[i]) begin
					lo_q[i] <= lo[i];
					hi_q[i] <= hi[i];
					cnt_q[i] <= cnt[i];
					ta_q[i] <= ta[i];
					tb_q[i] <= tb[i];
					got_q[i] <= 1'b1;
				end
			end
			if (busy_q && !pend_q && got_q == 2'b11) pend_q <= 1'b1;
			// Move merged result into the output register when free
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (pend_q && (!out_valid || !out_stall)) begin
				min_x <= lo_q[0]; min_y <= lo_q[1];
				max_x <= hi_q[0]; max_y <= hi_q[1];
				count_x <= cnt_q[0]; count_y <= cnt_q[1];
				root_0 <= r0; root_1 <= r1; root_2 <= r2; root_3 <= r3;
				out_valid <= 1'b1;
				pend_q <= 1'b0;
				busy_q <= 1'b0;
				got_q <= '0;
			end
		end
	end
endmodule
